### sv/mrpt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and modular helpers for the primality tester.
// No dependencies.
package mrpt_pkg;

  localparam int NUM_WIDTH   = 64;
  localparam int BIT_W       = $clog2(NUM_WIDTH);
  localparam int TRIAL_COUNT = 46;
  localparam int BASE_COUNT  = 7;
  localparam int PIDX_W      = $clog2(TRIAL_COUNT);
  localparam int WIDX_W      = $clog2(BASE_COUNT);

  localparam logic [7:0] TRIAL_PRIMES [TRIAL_COUNT] = '{
    8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23, 8'd29, 8'd31, 8'd37,
    8'd41, 8'd43, 8'd47, 8'd53, 8'd59, 8'd61, 8'd67, 8'd71, 8'd73, 8'd79, 8'd83,
    8'd89, 8'd97, 8'd101, 8'd103, 8'd107, 8'd109, 8'd113, 8'd127, 8'd131, 8'd137,
    8'd139, 8'd149, 8'd151, 8'd157, 8'd163, 8'd167, 8'd173, 8'd179, 8'd181, 8'd191,
    8'd193, 8'd197, 8'd199
  };

  localparam logic [7:0] WITNESS_BASES [BASE_COUNT] = '{
    8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17
  };

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_TRIAL_INIT,
    OP_TRIAL_STEP,
    OP_NEXT_PRIME,
    OP_SPLIT_INIT,
    OP_SPLIT_STEP,
    OP_POW_INIT,
    OP_POW_SHIFT,
    OP_MUL_XB,
    OP_MUL_BB,
    OP_MUL_XX,
    OP_MUL_DBL,
    OP_MUL_DBL_DEC,
    OP_MUL_ADD,
    OP_MUL_ADD_DEC,
    OP_WR_X,
    OP_WR_B,
    OP_R_INC,
    OP_NEXT_BASE
  } dp_op_t;

  typedef struct packed {
    logic n_lt2;
    logic rem_zero;
    logic n_eq_p;
    logic prime_last;
    logic base_last;
    logic bcnt_zero;
    logic d_odd;
    logic e_zero;
    logic e_odd;
    logic my_bit;
    logic x_one;
    logic x_nm1;
    logic r_lt_s;
  } dp_status_t;

  // (x + y) mod m for x, y < m
  function automatic logic [NUM_WIDTH-1:0] mod_add(input logic [NUM_WIDTH-1:0] x,
                                                   input logic [NUM_WIDTH-1:0] y,
                                                   input logic [NUM_WIDTH-1:0] m);
    logic [NUM_WIDTH-1:0] gap;
    gap = m - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

endpackage

### sv/mrpt_dp.sv
`timescale 1ns / 1ps
// Datapath: trial remainder, shift-and-add modular multiply, exponent registers.
// Uses mrpt_pkg; driven by mrpt_ctrl.
module mrpt_dp (
  input  logic                          clk,
  input  logic [63:0]                   candidate,
  input  mrpt_pkg::dp_op_t              op,
  output mrpt_pkg::dp_status_t          status
);

  logic [mrpt_pkg::NUM_WIDTH-1:0] n, d, e, b, x, ma, mx, my;
  logic [mrpt_pkg::BIT_W-1:0]     bcnt, s, r;
  logic [mrpt_pkg::PIDX_W-1:0]    pidx;
  logic [mrpt_pkg::WIDX_W-1:0]    widx;
  logic [7:0]                     rem;
  logic [7:0]                     p;
  logic [8:0]                     tsum;
  logic [mrpt_pkg::NUM_WIDTH-1:0] nm1;

  assign p    = mrpt_pkg::TRIAL_PRIMES[pidx];
  assign tsum = {rem, n[bcnt]};
  assign nm1  = n - 1'b1;

  always_ff @(posedge clk) begin
    unique case (op)
      mrpt_pkg::OP_LOAD: begin
        n    <= candidate[mrpt_pkg::NUM_WIDTH-1:0];
        pidx <= '0;
        widx <= '0;
      end
      mrpt_pkg::OP_TRIAL_INIT: begin
        rem  <= '0;
        bcnt <= mrpt_pkg::BIT_W'(mrpt_pkg::NUM_WIDTH - 1);
      end
      mrpt_pkg::OP_TRIAL_STEP: begin
        rem  <= (tsum >= {1'b0, p}) ? 8'(tsum - {1'b0, p}) : tsum[7:0];
        bcnt <= bcnt - 1'b1;
      end
      mrpt_pkg::OP_NEXT_PRIME: pidx <= pidx + 1'b1;
      mrpt_pkg::OP_SPLIT_INIT: begin
        d <= nm1;
        s <= '0;
      end
      mrpt_pkg::OP_SPLIT_STEP: begin
        d <= d >> 1;
        s <= s + 1'b1;
      end
      mrpt_pkg::OP_POW_INIT: begin
        x <= mrpt_pkg::NUM_WIDTH'(1);
        b <= mrpt_pkg::NUM_WIDTH'(mrpt_pkg::WITNESS_BASES[widx]);
        e <= d;
        r <= mrpt_pkg::BIT_W'(1);
      end
      mrpt_pkg::OP_POW_SHIFT: e <= e >> 1;
      mrpt_pkg::OP_MUL_XB, mrpt_pkg::OP_MUL_BB, mrpt_pkg::OP_MUL_XX: begin
        mx   <= (op == mrpt_pkg::OP_MUL_BB) ? b : x;
        my   <= (op == mrpt_pkg::OP_MUL_XX) ? x : b;
        ma   <= '0;
        bcnt <= mrpt_pkg::BIT_W'(mrpt_pkg::NUM_WIDTH - 1);
      end
      mrpt_pkg::OP_MUL_DBL: ma <= mrpt_pkg::mod_add(ma, ma, n);
      mrpt_pkg::OP_MUL_DBL_DEC: begin
        ma   <= mrpt_pkg::mod_add(ma, ma, n);
        bcnt <= bcnt - 1'b1;
      end
      mrpt_pkg::OP_MUL_ADD: ma <= mrpt_pkg::mod_add(ma, mx, n);
      mrpt_pkg::OP_MUL_ADD_DEC: begin
        ma   <= mrpt_pkg::mod_add(ma, mx, n);
        bcnt <= bcnt - 1'b1;
      end
      mrpt_pkg::OP_WR_X: x <= ma;
      mrpt_pkg::OP_WR_B: b <= ma;
      mrpt_pkg::OP_R_INC: r <= r + 1'b1;
      mrpt_pkg::OP_NEXT_BASE: widx <= widx + 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    status.n_lt2      = (n < mrpt_pkg::NUM_WIDTH'(2));
    status.rem_zero   = (rem == '0);
    status.n_eq_p     = (n == mrpt_pkg::NUM_WIDTH'(p));
    status.prime_last = (pidx == mrpt_pkg::PIDX_W'(mrpt_pkg::TRIAL_COUNT - 1));
    status.base_last  = (widx == mrpt_pkg::WIDX_W'(mrpt_pkg::BASE_COUNT - 1));
    status.bcnt_zero  = (bcnt == '0);
    status.d_odd      = d[0];
    status.e_zero     = (e == '0);
    status.e_odd      = e[0];
    status.my_bit     = my[bcnt];
    status.x_one      = (x == mrpt_pkg::NUM_WIDTH'(1));
    status.x_nm1      = (x == nm1);
    status.r_lt_s     = (r < s);
  end

endmodule

### sv/mrpt_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences trial division and Miller-Rabin rounds, holds the result register.
// Uses mrpt_pkg; commands mrpt_dp.
module mrpt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cand_valid,
  output logic                  cand_stall,
  output logic                  flag_valid,
  input  logic                  flag_stall,
  output logic                  prime_flag,
  output mrpt_pkg::dp_op_t      op,
  input  mrpt_pkg::dp_status_t  status
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_TINIT, S_TSTEP, S_TEVAL, S_SPLIT, S_PINIT, S_PLOOP,
    S_PSQ, S_PSHIFT, S_PCHECK, S_RLOOP, S_RCHK, S_MDBL, S_MADD, S_MWR
  } state_t;

  state_t state, state_next, ret, ret_next;
  logic   dest_b, dest_b_next;
  logic   result, result_next;
  logic   done_next;
  // a finished verdict waits here while the output register is still full
  logic   held;
  logic   done_pending;

  assign done_pending = held;
  assign cand_stall   = (state != S_IDLE) || done_pending;

  always_comb begin
    state_next  = state;
    ret_next    = ret;
    dest_b_next = dest_b;
    result_next = result;
    done_next   = 1'b0;
    op          = mrpt_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (cand_valid && !done_pending) begin
          op         = mrpt_pkg::OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.n_lt2) begin
          result_next = 1'b0;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_TINIT;
        end
      end
      S_TINIT: begin
        op         = mrpt_pkg::OP_TRIAL_INIT;
        state_next = S_TSTEP;
      end
      S_TSTEP: begin
        op = mrpt_pkg::OP_TRIAL_STEP;
        if (status.bcnt_zero) state_next = S_TEVAL;
      end
      S_TEVAL: begin
        if (status.rem_zero) begin
          result_next = status.n_eq_p;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else if (status.prime_last) begin
          op         = mrpt_pkg::OP_SPLIT_INIT;
          state_next = S_SPLIT;
        end else begin
          op         = mrpt_pkg::OP_NEXT_PRIME;
          state_next = S_TINIT;
        end
      end
      S_SPLIT: begin
        if (status.d_odd) state_next = S_PINIT;
        else op = mrpt_pkg::OP_SPLIT_STEP;
      end
      S_PINIT: begin
        op         = mrpt_pkg::OP_POW_INIT;
        state_next = S_PLOOP;
      end
      S_PLOOP: begin
        if (status.e_zero) begin
          state_next = S_PCHECK;
        end else if (status.e_odd) begin
          op          = mrpt_pkg::OP_MUL_XB;
          dest_b_next = 1'b0;
          ret_next    = S_PSQ;
          state_next  = S_MDBL;
        end else begin
          state_next = S_PSQ;
        end
      end
      S_PSQ: begin
        op          = mrpt_pkg::OP_MUL_BB;
        dest_b_next = 1'b1;
        ret_next    = S_PSHIFT;
        state_next  = S_MDBL;
      end
      S_PSHIFT: begin
        op         = mrpt_pkg::OP_POW_SHIFT;
        state_next = S_PLOOP;
      end
      S_PCHECK, S_RCHK: begin
        if (status.x_nm1 || (state == S_PCHECK && status.x_one)) begin
          if (status.base_last) begin
            result_next = 1'b1;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end else begin
            op         = mrpt_pkg::OP_NEXT_BASE;
            state_next = S_PINIT;
          end
        end else begin
          if (state == S_RCHK) op = mrpt_pkg::OP_R_INC;
          state_next = S_RLOOP;
        end
      end
      S_RLOOP: begin
        if (!status.r_lt_s) begin
          result_next = 1'b0;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          op          = mrpt_pkg::OP_MUL_XX;
          dest_b_next = 1'b0;
          ret_next    = S_RCHK;
          state_next  = S_MDBL;
        end
      end
      S_MDBL: begin
        if (status.my_bit) begin
          op         = mrpt_pkg::OP_MUL_DBL;
          state_next = S_MADD;
        end else if (status.bcnt_zero) begin
          op         = mrpt_pkg::OP_MUL_DBL;
          state_next = S_MWR;
        end else begin
          op = mrpt_pkg::OP_MUL_DBL_DEC;
        end
      end
      S_MADD: begin
        if (status.bcnt_zero) begin
          op         = mrpt_pkg::OP_MUL_ADD;
          state_next = S_MWR;
        end else begin
          op         = mrpt_pkg::OP_MUL_ADD_DEC;
          state_next = S_MDBL;
        end
      end
      S_MWR: begin
        op         = dest_b ? mrpt_pkg::OP_WR_B : mrpt_pkg::OP_WR_X;
        state_next = ret;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      dest_b     <= 1'b0;
      result     <= 1'b0;
      held       <= 1'b0;
      flag_valid <= 1'b0;
      prime_flag <= 1'b0;
    end else begin
      state  <= state_next;
      ret    <= ret_next;
      dest_b <= dest_b_next;
      result <= result_next;
      if (done_next || held) begin
        if (!flag_valid || !flag_stall) begin
          flag_valid <= 1'b1;
          prime_flag <= result_next;
          held       <= 1'b0;
        end else begin
          held <= 1'b1;
        end
      end else if (flag_valid && !flag_stall) begin
        flag_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (cand_valid && !cand_stall) |=> state == S_CHECK)
    else $error("accepted item did not start a test");
  a_mul_full: assert property (@(posedge clk) disable iff (rst)
    state == S_MWR |-> status.bcnt_zero)
    else $error("multiply written back before its last bit");
  a_held_idle: assert property (@(posedge clk) disable iff (rst)
    held |-> state == S_IDLE && flag_valid)
    else $error("held verdict outside idle");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (flag_valid && flag_stall) |=> flag_valid)
    else $error("pending result dropped");
`endif

endmodule

### sv/miller_rabin_prime_test.sv
`timescale 1ns / 1ps
// 64-bit Miller-Rabin primality tester with seven fixed witness bases, one item at a time.
// Trial division by up to 46 small primes comes first, then each of up to seven bases costs
// one modular exponentiation of up to 63 squarings and up to 63 multiplies, each multiply
// done bit by bit with its setup in the shift-and-add unit.
// Synchronous active-high reset returns the controller to idle with no result pending.
module miller_rabin_prime_test (
  input  logic        clk,
  input  logic        rst,
  input  logic        cand_valid,
  output logic        cand_stall,
  input  logic [63:0] candidate,
  output logic        flag_valid,
  input  logic        flag_stall,
  output logic        prime_flag
);

  mrpt_pkg::dp_op_t     op;
  mrpt_pkg::dp_status_t status;

  mrpt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .flag_valid (flag_valid),
    .flag_stall (flag_stall),
    .prime_flag (prime_flag),
    .op         (op),
    .status     (status)
  );

  mrpt_dp u_dp (
    .clk       (clk),
    .candidate (candidate),
    .op        (op),
    .status    (status)
  );

endmodule
